>>> hdl/ptd_pkg.sv
`default_nettype none

package ptd_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned DeltaW  = 16;
  localparam int unsigned HandleW = 8;
  localparam int unsigned ActW    = 2;

  localparam logic [ActW-1:0] ACT_INIT     = 2'd0;
  localparam logic [ActW-1:0] ACT_START    = 2'd1;
  localparam logic [ActW-1:0] ACT_DISPATCH = 2'd2;

  localparam logic [TimeW-1:0] NO_ACTIVE_SLOT = 32'hFFFF_FFFF;

  // Token that walks the slot chain during a dispatch
  typedef struct packed {
    logic               vld;
    logic               found;
    logic [HandleW-1:0] handle;
    logic [TimeW-1:0]   idle;
    logic [TimeW-1:0]   elapsed;
  } carry_t;

  // Slot load for a start
  typedef struct packed {
    logic [DeltaW-1:0]  delay;
    logic [DeltaW-1:0]  period;
    logic [HandleW-1:0] handle;
  } slot_wr_t;

  function automatic logic [TimeW-1:0] sext16(input logic [DeltaW-1:0] v);
    sext16 = {{(TimeW-DeltaW){v[DeltaW-1]}}, v};
  endfunction

endpackage

`default_nettype wire

>>> hdl/ptd_cell.sv
`default_nettype none

module ptd_cell
  import ptd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     wr_en_i,
  input  wire slot_wr_t wr_i,
  input  wire carry_t   carry_i,
  output carry_t        carry_o
);

  logic               act_q;
  logic [TimeW-1:0]   rem_q, rem_d;
  logic [DeltaW-1:0]  per_q;
  logic [HandleW-1:0] hdl_q;
  carry_t             carry_q, carry_d;

  logic [TimeW-1:0] diff, reload;
  logic             hit, due, take;

  always_comb begin
    diff   = rem_q - carry_i.elapsed;
    reload = rem_q + sext16(per_q) - carry_i.elapsed;
    due    = (diff == '0) || diff[TimeW-1];
    hit    = carry_i.vld && act_q;
    take   = hit && due && !carry_i.found;

    if (wr_en_i) begin
      rem_d = sext16(wr_i.delay);
    end else if (take) begin
      rem_d = reload;
    end else if (hit) begin
      rem_d = diff;
    end else begin
      rem_d = rem_q;
    end

    carry_d = carry_i;
    if (hit) begin
      carry_d.found = carry_i.found | due;
      if (take) begin
        carry_d.handle = hdl_q;
      end
      // idle stays at zero once any slot is due
      if (due) begin
        carry_d.idle = '0;
      end else if (diff < carry_i.idle) begin
        carry_d.idle = diff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      carry_q <= '0;
    end else begin
      carry_q <= carry_d;
      if (wr_en_i) begin
        act_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    if (wr_en_i) begin
      per_q <= wr_i.period;
      hdl_q <= wr_i.handle;
    end
  end

  assign carry_o = carry_q;

endmodule

`default_nettype wire

>>> hdl/periodic_task_dispatcher_top.sv
// Init, start and unused codes: the result passes the pending register, then the output register.
// Dispatch: a token walks the slot cells one per cycle, then its result passes the pending
// register and the output register before out_valid rises.
// A new word is taken only once a dispatch token has left the last cell and the pending
// register is empty; one result may wait in the output register while the next is taken.
// rst_ni (async, active low) clears all slots to inactive, the fill count and the time base.
`default_nettype none

module periodic_task_dispatcher_top
  import ptd_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [ActW-1:0]     action_i,
  input  wire logic [TimeW-1:0]    now_ms_i,
  input  wire logic signed [DeltaW-1:0] start_delay_i,
  input  wire logic signed [DeltaW-1:0] start_period_i,
  input  wire logic [HandleW-1:0]  start_handle_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     task_due_o,
  output logic [HandleW-1:0]       due_handle_o,
  output logic [TimeW-1:0]         wait_ms_o,
  output logic                     start_accepted_o
);

  localparam int unsigned FreeW = $clog2(MAX_SLOTS + 1);

  typedef struct packed {
    logic               task_due;
    logic [HandleW-1:0] due_handle;
    logic [TimeW-1:0]   wait_ms;
    logic               start_accepted;
  } res_t;

  logic             busy_q, busy_d;
  logic [FreeW-1:0] free_q, free_d;
  logic [TimeW-1:0] last_q, last_d;
  logic             pend_vld_q, pend_vld_d, out_vld_q, out_vld_d;
  res_t             pend_q, pend_d, out_q;
  carry_t           tok_q, tok_d;
  carry_t           chain [MAX_SLOTS+1];
  logic [MAX_SLOTS-1:0] wr_en;
  slot_wr_t         wr;

  logic accept, move, table_full;

  assign in_ready_o = !busy_q && !pend_vld_q;
  assign accept     = in_valid_i && in_ready_o;
  assign move       = pend_vld_q && (!out_vld_q || out_ready_i);
  assign table_full = (free_q == FreeW'(MAX_SLOTS));

  assign wr.delay  = start_delay_i;
  assign wr.period = start_period_i;
  assign wr.handle = start_handle_i;

  always_comb begin
    busy_d      = busy_q;
    free_d      = free_q;
    last_d      = last_q;
    pend_vld_d  = pend_vld_q;
    pend_d      = pend_q;
    tok_d       = tok_q;
    tok_d.vld   = 1'b0;
    wr_en       = '0;

    if (move) begin
      pend_vld_d = 1'b0;
    end

    if (accept) begin
      pend_d = '0;
      unique case (action_i)
        ACT_INIT: begin
          last_d     = now_ms_i;
          pend_vld_d = 1'b1;
        end
        ACT_START: begin
          pend_vld_d = 1'b1;
          if (!table_full) begin
            for (int i = 0; i < MAX_SLOTS; i++) begin
              wr_en[i] = (free_q == FreeW'(i));
            end
            free_d                = free_q + 1'b1;
            pend_d.start_accepted = 1'b1;
          end
        end
        ACT_DISPATCH: begin
          last_d        = now_ms_i;
          tok_d.vld     = 1'b1;
          tok_d.found   = 1'b0;
          tok_d.handle  = '0;
          tok_d.idle    = NO_ACTIVE_SLOT;
          tok_d.elapsed = now_ms_i - last_q;
          busy_d        = 1'b1;
        end
        default: begin
          pend_vld_d = 1'b1;
        end
      endcase
    end

    // token leaves the last cell: dispatch result
    if (chain[MAX_SLOTS].vld) begin
      busy_d            = 1'b0;
      pend_vld_d        = 1'b1;
      pend_d.task_due   = chain[MAX_SLOTS].found;
      pend_d.due_handle = chain[MAX_SLOTS].handle;
      pend_d.wait_ms    = chain[MAX_SLOTS].idle;
      pend_d.start_accepted = 1'b0;
    end

    out_vld_d = move ? 1'b1 : (out_ready_i ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      free_q     <= '0;
      last_q     <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      tok_q      <= '0;
    end else begin
      busy_q     <= busy_d;
      free_q     <= free_d;
      last_q     <= last_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      tok_q      <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (move) begin
      out_q <= pend_q;
    end
  end

  assign chain[0] = tok_q;

  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
    ptd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .wr_en_i (wr_en[g]),
      .wr_i    (wr),
      .carry_i (chain[g]),
      .carry_o (chain[g+1])
    );
  end

  assign out_valid_o      = out_vld_q;
  assign task_due_o       = out_q.task_due;
  assign due_handle_o     = out_q.due_handle;
  assign wait_ms_o        = out_q.wait_ms;
  assign start_accepted_o = out_q.start_accepted;

endmodule

`default_nettype wire

>>> hdl/ptd_checker.sv
`default_nettype none

module ptd_checker
  import ptd_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic               task_due_o,
  input wire logic [HandleW-1:0] due_handle_o,
  input wire logic [TimeW-1:0]   wait_ms_o,
  input wire logic               start_accepted_o
);

  // a stalled result word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(wait_ms_o))
    else $error("result word dropped while stalled");

  a_handle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !task_due_o |-> due_handle_o == '0)
    else $error("handle set without a due task");

  a_due_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && task_due_o |-> wait_ms_o == '0 && !start_accepted_o)
    else $error("due task with nonzero idle time");

  a_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && start_accepted_o |-> !task_due_o && wait_ms_o == '0)
    else $error("start result carries dispatch fields");

endmodule

bind periodic_task_dispatcher_top ptd_checker u_ptd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .task_due_o       (task_due_o),
  .due_handle_o     (due_handle_o),
  .wait_ms_o        (wait_ms_o),
  .start_accepted_o (start_accepted_o)
);

`default_nettype wire

>>> tb/periodic_task_dispatcher_top_tb.sv
`default_nettype none

module periodic_task_dispatcher_top_tb
  import ptd_pkg::*;
;

  localparam int unsigned SLOTS = 8;
  localparam logic [ActW-1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned LONG_HOLD = 300;

  typedef struct packed {
    logic               due;
    logic [HandleW-1:0] handle;
    logic [TimeW-1:0]   idle;
    logic               accepted;
  } outcome_t;

  // Mirror of the task table; one expected word per accepted input word
  class dispatch_scoreboard;
    logic [TimeW-1:0]   remaining [SLOTS];
    logic [DeltaW-1:0]  reload [SLOTS];
    logic [HandleW-1:0] tag [SLOTS];
    bit                 live [SLOTS];
    int unsigned        fill;
    logic [TimeW-1:0]   time_base;
    outcome_t           expected_q[$];
    int unsigned        errors, dispatches, due_seen, taken, refused, checked;

    function new();
      foreach (live[i]) live[i] = 1'b0;
      fill = 0;
      time_base = '0;
      errors = 0;
      dispatches = 0;
      due_seen = 0;
      taken = 0;
      refused = 0;
      checked = 0;
    endfunction

    function void note_word(logic [ActW-1:0] act, logic [TimeW-1:0] now,
                            logic [DeltaW-1:0] dly, logic [DeltaW-1:0] per,
                            logic [HandleW-1:0] hdl);
      outcome_t o;
      logic [TimeW-1:0] elapsed;
      o = '0;
      case (act)
        ACT_INIT: time_base = now;
        ACT_START: begin
          if (fill < SLOTS) begin
            remaining[fill] = {{(TimeW-DeltaW){dly[DeltaW-1]}}, dly};
            reload[fill] = per;
            tag[fill] = hdl;
            live[fill] = 1'b1;
            fill++;
            o.accepted = 1'b1;
            taken++;
          end else begin
            refused++;
          end
        end
        ACT_DISPATCH: begin
          elapsed = now - time_base;
          time_base = now;
          o.idle = NO_ACTIVE_SLOT;
          dispatches++;
          for (int i = 0; i < SLOTS; i++) begin
            if (live[i]) begin
              remaining[i] = remaining[i] - elapsed;
              // zero or negative counts as due
              if (remaining[i] == '0 || remaining[i][TimeW-1]) begin
                if (!o.due) begin
                  o.due = 1'b1;
                  o.handle = tag[i];
                  remaining[i] = remaining[i] +
                                 {{(TimeW-DeltaW){reload[i][DeltaW-1]}}, reload[i]};
                end
                o.idle = '0;
              end else if (remaining[i] < o.idle) begin
                o.idle = remaining[i];
              end
            end
          end
          if (o.due) due_seen++;
        end
        default: ;
      endcase
      expected_q.push_back(o);
    endfunction

    function void field_ok(string name, logic [TimeW-1:0] want, logic [TimeW-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected, actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      field_ok("task_due", TimeW'(want.due), TimeW'(got.due));
      field_ok("due_handle", TimeW'(want.handle), TimeW'(got.handle));
      field_ok("wait_ms", want.idle, got.idle);
      field_ok("start_accepted", TimeW'(want.accepted), TimeW'(got.accepted));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [ActW-1:0]     action = ACT_UNUSED;
  logic [TimeW-1:0]    now_ms = '0;
  logic [DeltaW-1:0]   start_delay = '0;
  logic [DeltaW-1:0]   start_period = '0;
  logic [HandleW-1:0]  start_handle = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                task_due;
  logic [HandleW-1:0]  due_handle;
  logic [TimeW-1:0]    wait_ms;
  logic                start_accepted;

  bit calm = 1'b0;
  bit hold_req = 1'b0;

  dispatch_scoreboard sb = new();

  periodic_task_dispatcher_top #(
    .MAX_SLOTS(SLOTS)
  ) uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .action_i        (action),
    .now_ms_i        (now_ms),
    .start_delay_i   (start_delay),
    .start_period_i  (start_period),
    .start_handle_i  (start_handle),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .task_due_o      (task_due),
    .due_handle_o    (due_handle),
    .wait_ms_o       (wait_ms),
    .start_accepted_o(start_accepted)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_word(action, now_ms, start_delay, start_period, start_handle);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{task_due, due_handle, wait_ms, start_accepted});
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        hold_req = 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic push_word(input logic [ActW-1:0] act, input logic [TimeW-1:0] now,
                           input logic [DeltaW-1:0] dly, input logic [DeltaW-1:0] per,
                           input logic [HandleW-1:0] hdl);
    in_valid     <= 1'b1;
    action       <= act;
    now_ms       <= now;
    start_delay  <= dly;
    start_period <= per;
    start_handle <= hdl;
    do @(posedge clk); while (!in_ready);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic push_random_start();
    push_word(ACT_START, $urandom(), DeltaW'($urandom_range(0, 16'hFFFF)),
              DeltaW'($urandom_range(0, 16'hFFFF)), HandleW'($urandom_range(0, 255)));
  endtask

  initial begin
    logic [TimeW-1:0] cur_now;
    int unsigned work, pick, n;
    work = 0;
    n = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // no slot active yet; the first dispatch sees the time base at its reset value
    push_word(ACT_DISPATCH, 32'h0000_0003, '0, '0, '0);
    push_word(ACT_DISPATCH, 32'hFFFF_FFFF, '0, '0, '0);
    push_word(ACT_UNUSED, '1, '1, '1, '1);
    push_word(ACT_INIT, 32'hFFFF_FFF8, '0, '0, '0);
    // slot table: extreme delays and periods, plus a spread of ordinary tasks
    push_word(ACT_START, '0, 16'd0, 16'd60, 8'h00);
    push_word(ACT_START, '0, 16'h8000, 16'h7FFF, 8'hFF);
    push_word(ACT_START, '0, 16'd10, 16'd150, 8'h11);
    push_word(ACT_START, '0, 16'd25, 16'd200, 8'h22);
    push_word(ACT_START, '0, 16'hFFFF, 16'd300, 8'h33);
    push_word(ACT_START, '0, 16'd70, 16'd500, 8'h44);
    push_word(ACT_START, '0, 16'h7FFF, 16'd1000, 8'h55);
    push_word(ACT_START, '0, 16'd6000, 16'h8000, 8'h66);
    // table full from here on
    push_word(ACT_START, '0, 16'h1234, 16'h0042, 8'hC3);
    // time base wraps: elapsed 10, several slots due at once
    push_word(ACT_DISPATCH, 32'h0000_0002, '0, '0, '0);
    push_word(ACT_DISPATCH, 32'h0000_0002, '0, '0, '0);
    push_word(ACT_DISPATCH, 32'h0000_0001, '0, '0, '0);
    push_word(ACT_UNUSED, '0, '0, '0, '0);
    push_word(ACT_INIT, 32'h8000_0000, '0, '0, '0);
    push_word(ACT_DISPATCH, 32'h8000_0014, '0, '0, '0);
    push_word(ACT_START, '1, 16'h8000, 16'h7FFF, 8'h00);
    cur_now = 32'h8000_0014;

    // mostly dispatches with small forward steps; inits move the time base anywhere
    while (work < 1080) begin
      if (n == 150) hold_req = 1'b1;
      if (work == 980) calm = 1'b1;
      n++;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        push_word(ACT_UNUSED, $urandom(), DeltaW'($urandom()), DeltaW'($urandom()),
                  HandleW'($urandom()));
        work++;
      end else if (pick < 10) begin
        cur_now = $urandom();
        push_word(ACT_INIT, cur_now, DeltaW'($urandom()), DeltaW'($urandom()),
                  HandleW'($urandom()));
        work++;
      end else if (pick < 16) begin
        push_random_start();
        work++;
      end else begin
        if ($urandom_range(0, 19) == 0)
          cur_now = cur_now - $urandom_range(1, 30);
        else
          cur_now = cur_now + $urandom_range(0, 20);
        push_word(ACT_DISPATCH, cur_now, DeltaW'($urandom()), DeltaW'($urandom()),
                  HandleW'($urandom()));
        work++;
      end
    end
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SLOTS + 12) @(posedge clk);

    $display("ran %0d dispatches (%0d found a task due), %0d starts taken, %0d refused",
             sb.dispatches, sb.due_seen, sb.taken, sb.refused);
    $display("%0d result words checked, %0d errors", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("periodic_task_dispatcher_top: match");
    end else begin
      $display("periodic_task_dispatcher_top: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d result words still outstanding", sb.expected_q.size());
    $display("periodic_task_dispatcher_top: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
